// ----- design/edf_pkg.sv -----
// Shared constants and types for the escaped frame deframer.
package edf_pkg;

  localparam int BUFFER_BYTES = 64;
  localparam int BUF_AW       = $clog2(BUFFER_BYTES);
  localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
  localparam int LIMIT_W      = 7;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);
  localparam logic [LIMIT_W-1:0] LIMIT_MAX   = LIMIT_W'(BUFFER_BYTES);

  localparam logic [7:0] CH_START = 8'h40;
  localparam logic [7:0] CH_END   = 8'h23;
  localparam logic [7:0] CH_ESC   = 8'h2A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;

  typedef enum logic [1:0] {
    Q_CMD,
    Q_STORE,
    Q_CLOSE
  } q_op_t;

  typedef struct packed {
    q_op_t      op;
    logic [7:0] data;
    logic       tail;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic     empty;
    q_entry_t head;
  } q_head_t;

  typedef enum logic [1:0] {
    B_RUN,
    B_READ,
    B_SEND,
    B_EMPTY
  } back_state_t;

endpackage

// ----- design/edf_rx_if.sv -----
// Received byte channel.
interface edf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// ----- design/edf_res_if.sv -----
// Decoded result channel.
interface edf_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] command;
  logic [7:0] data_byte;
  logic       has_data;
  logic       last;

  modport source (output valid, output command, output data_byte, output has_data,
                  output last, input ready);
  modport sink (input valid, input command, input data_byte, input has_data,
                input last, output ready);
endinterface

// ----- design/edf_cfg_if.sv -----
// Configuration write channel for the raw byte limit.
interface edf_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] raw_limit;

  modport source (output valid, output raw_limit, input ready);
  modport sink (input valid, input raw_limit, output ready);
endinterface

// ----- design/edf_front.sv -----
// Front end: frame tracking, unescaping and classification of received bytes.
module edf_front (
  input  logic             clk,
  input  logic             rst,
  edf_rx_if.sink           rx,
  edf_cfg_if.sink          cfg,
  input  logic             q_full,
  output edf_pkg::q_push_t q_push
);
  import edf_pkg::*;

  logic               in_frame;
  logic               in_frame_next;
  logic [LIMIT_W-1:0] raw_count;
  logic [LIMIT_W-1:0] raw_count_next;
  logic               escape_pending;
  logic               escape_pending_next;
  logic [LIMIT_W-1:0] raw_limit;
  logic [LIMIT_W-1:0] limit_eff;
  logic               accept;

  assign cfg.ready = 1'b1;
  assign rx.ready  = !q_full;
  assign accept    = rx.valid && rx.ready;
  assign limit_eff = (raw_limit > LIMIT_MAX) ? LIMIT_MAX : raw_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_limit <= LIMIT_RESET;
    end else if (cfg.valid) begin
      raw_limit <= cfg.raw_limit;
    end
  end

  always_comb begin
    q_push              = '0;
    q_push.entry.op     = Q_STORE;
    q_push.entry.data   = rx.in_byte;
    q_push.entry.tail   = 1'b0;
    in_frame_next       = in_frame;
    raw_count_next      = raw_count;
    escape_pending_next = escape_pending;
    if (accept) begin
      if (!in_frame) begin
        if (rx.in_byte == CH_START) begin
          in_frame_next = 1'b1;
        end
      end else if (rx.in_byte == CH_END) begin
        // close; a dangling escape becomes a trailing start character
        q_push.push         = (raw_count != '0);
        q_push.entry.op     = Q_CLOSE;
        q_push.entry.tail   = escape_pending;
        in_frame_next       = 1'b0;
        raw_count_next      = '0;
        escape_pending_next = 1'b0;
      end else if (raw_count >= limit_eff) begin
        // overflow: drop the frame
        in_frame_next       = 1'b0;
        raw_count_next      = '0;
        escape_pending_next = 1'b0;
      end else begin
        raw_count_next = raw_count + LIMIT_W'(1);
        if (raw_count == '0) begin
          q_push.push     = 1'b1;
          q_push.entry.op = Q_CMD;
        end else if (escape_pending) begin
          q_push.push         = 1'b1;
          escape_pending_next = 1'b0;
          case (rx.in_byte)
            CH_ZERO: q_push.entry.data = CH_ESC;
            CH_ONE:  q_push.entry.data = CH_END;
            default: q_push.entry.data = CH_START;
          endcase
        end else if (rx.in_byte == CH_ESC) begin
          escape_pending_next = 1'b1;
        end else begin
          q_push.push = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      raw_count      <= '0;
      escape_pending <= 1'b0;
    end else begin
      in_frame       <= in_frame_next;
      raw_count      <= raw_count_next;
      escape_pending <= escape_pending_next;
    end
  end

`ifndef SYNTHESIS
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> (raw_count == '0) && !escape_pending)
    else $error("front state not cleared outside a frame");
`endif

endmodule

// ----- design/edf_queue.sv -----
// Short queue of classified operations between front and back.
module edf_queue (
  input  logic             clk,
  input  logic             rst,
  input  edf_pkg::q_push_t q_push,
  output logic             q_full,
  input  logic             q_pop,
  output edf_pkg::q_head_t q_head
);
  import edf_pkg::*;

  q_entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign q_full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_head.empty = (count == '0);
  assign q_head.head  = slots[rd_ptr];
  assign do_push      = q_push.push && !q_full;
  assign do_pop       = q_pop && !q_head.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= q_push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push.push |-> !q_full)
    else $error("push into a full queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

// ----- design/edf_back.sv -----
// Back end: payload store and emission of each completed frame's results.
module edf_back (
  input  logic             clk,
  input  logic             rst,
  input  edf_pkg::q_head_t q_head,
  output logic             q_pop,
  edf_res_if.source        res
);
  import edf_pkg::*;

  back_state_t      state;
  back_state_t      state_next;
  logic [7:0]       mem [BUFFER_BYTES];
  logic [CNT_W-1:0] wr_count;
  logic [CNT_W-1:0] rd_idx;
  logic [CNT_W-1:0] last_idx;
  logic [CNT_W-1:0] close_total;
  logic [7:0]       command_hold;
  logic [7:0]       rd_data;
  logic             mem_we;
  logic [7:0]       mem_wdata;
  logic             out_free;
  logic             load_data;
  logic             load_empty;
  logic             res_valid;
  logic [7:0]       res_command;
  logic [7:0]       res_data;
  logic             res_has;
  logic             res_last;

  assign out_free    = !res_valid || res.ready;
  assign close_total = wr_count + CNT_W'(q_head.head.tail);

  assign res.valid     = res_valid;
  assign res.command   = res_command;
  assign res.data_byte = res_data;
  assign res.has_data  = res_has;
  assign res.last      = res_last;

  always_comb begin
    state_next = state;
    unique case (state)
      B_RUN: begin
        if (!q_head.empty && q_head.head.op == Q_CLOSE) begin
          state_next = (close_total == '0) ? B_EMPTY : B_READ;
        end
      end
      B_READ:  state_next = B_SEND;
      B_SEND: begin
        if (out_free) begin
          state_next = (rd_idx == last_idx) ? B_RUN : B_READ;
        end
      end
      B_EMPTY: begin
        if (out_free) begin
          state_next = B_RUN;
        end
      end
      default: state_next = B_RUN;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    load_data  = 1'b0;
    load_empty = 1'b0;
    mem_we     = 1'b0;
    mem_wdata  = q_head.head.data;
    unique case (state)
      B_RUN: begin
        q_pop = !q_head.empty;
        if (q_head.head.op == Q_CLOSE) begin
          mem_we    = q_pop && q_head.head.tail;
          mem_wdata = CH_START;
        end else begin
          mem_we = q_pop && (q_head.head.op == Q_STORE);
        end
      end
      B_READ:  ;
      B_SEND:  load_data  = out_free;
      B_EMPTY: load_empty = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_count[BUF_AW-1:0]] <= mem_wdata;
    end
    rd_data <= mem[rd_idx[BUF_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_RUN;
      wr_count <= '0;
      rd_idx   <= '0;
      last_idx <= '0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        case (q_head.head.op)
          Q_CMD:   wr_count <= '0;
          Q_STORE: wr_count <= wr_count + CNT_W'(1);
          Q_CLOSE: begin
            rd_idx   <= '0;
            last_idx <= close_total - CNT_W'(1);
          end
          default: ;
        endcase
      end
      if (load_data) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.head.op == Q_CMD) begin
      command_hold <= q_head.head.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_data || load_empty) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_data) begin
      res_command <= command_hold;
      res_data    <= rd_data;
      res_has     <= 1'b1;
      res_last    <= (rd_idx == last_idx);
    end else if (load_empty) begin
      res_command <= command_hold;
      res_data    <= '0;
      res_has     <= 1'b0;
      res_last    <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == B_SEND) |-> (rd_idx <= last_idx))
    else $error("payload read past end of frame");
  a_store_room: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (wr_count < CNT_W'(BUFFER_BYTES)))
    else $error("payload store overflow");
  a_pop_only_run: assert property (@(posedge clk) disable iff (rst)
    (load_data || load_empty) |-> !q_pop)
    else $error("queue popped while emitting");
`endif

endmodule

// ----- design/escaped_frame_deframer.sv -----
// Top level of the escaped frame deframer.
// Receives one raw byte per transfer on rx, opens a frame on '@', takes the first byte
// as the command, unescapes the rest ('*0' -> '*', '*1' -> '#', '*x' -> '@') into a
// 64-byte payload store, and on '#' sends one result per decoded byte on res (or one
// no-data result for an empty payload), with last set on the final one. The front
// takes a byte every cycle as long as its 4-entry operation queue has room. Emission
// runs in the back: it dispatches the close, then for each result performs a registered
// payload read and then an output load, which an output stall holds back; meanwhile the
// queue absorbs the following bytes and rx.ready drops once it is full. cfg writes the
// raw byte limit (reset 64, values above 64 act as 64) and is always ready; write it
// only while idle.
module escaped_frame_deframer (
  input  logic      clk,
  input  logic      rst,
  edf_rx_if.sink    rx,
  edf_res_if.source res,
  edf_cfg_if.sink   cfg
);
  import edf_pkg::*;

  q_push_t q_push;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;

  edf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push)
  );

  edf_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_head (q_head)
  );

  edf_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_head (q_head),
    .q_pop  (q_pop),
    .res    (res)
  );

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the escaped frame deframer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import edf_pkg::*;

  typedef struct packed {
    logic [7:0] command;
    logic [7:0] data_byte;
    logic       has_data;
    logic       last;
  } frame_result_t;

  class deframe_scoreboard;
    logic [6:0]    raw_limit;
    bit            in_frame;
    int unsigned   raw_count;
    logic [7:0]    command_hold;
    bit            escape_pending;
    int unsigned   decoded_count;
    logic [7:0]    payload [BUFFER_BYTES];
    frame_result_t awaited_results [$];
    int unsigned   mismatches;

    function new();
      raw_limit    = LIMIT_RESET;
      command_hold = 8'h00;
      mismatches   = 0;
      foreach (payload[i]) payload[i] = 8'h00;
      close_frame();
    endfunction

    function void close_frame();
      in_frame       = 1'b0;
      raw_count      = 0;
      escape_pending = 1'b0;
      decoded_count  = 0;
    endfunction

    function void store_payload(logic [7:0] b);
      if (decoded_count < BUFFER_BYTES) begin
        payload[decoded_count] = b;
        decoded_count++;
      end
    endfunction

    // Advance the frame state by one accepted byte; queue any results it releases.
    function void decode_byte(logic [7:0] b);
      int unsigned   eff_limit;
      frame_result_t res;
      eff_limit = (raw_limit > BUFFER_BYTES) ? BUFFER_BYTES : raw_limit;
      if (!in_frame) begin
        if (b == CH_START) in_frame = 1'b1;
        return;
      end
      if (b == CH_END) begin
        if (raw_count >= 1) begin
          // a pending escape in front of the terminator decodes as a start byte
          if (escape_pending) store_payload(CH_START);
          if (decoded_count == 0) begin
            res = '{command: command_hold, data_byte: 8'h00, has_data: 1'b0, last: 1'b1};
            awaited_results.push_back(res);
          end else begin
            for (int unsigned i = 0; i < decoded_count; i++) begin
              res = '{command: command_hold, data_byte: payload[i], has_data: 1'b1,
                      last: (i + 1 == decoded_count)};
              awaited_results.push_back(res);
            end
          end
        end
        close_frame();
        return;
      end
      if (raw_count >= eff_limit) begin
        close_frame();
        return;
      end
      if (raw_count == 0) begin
        command_hold = b;
      end else if (escape_pending) begin
        case (b)
          CH_ZERO: store_payload(CH_ESC);
          CH_ONE:  store_payload(CH_END);
          default: store_payload(CH_START);
        endcase
        escape_pending = 1'b0;
      end else if (b == CH_ESC) begin
        escape_pending = 1'b1;
      end else begin
        store_payload(b);
      end
      raw_count++;
    endfunction

    function void compare_result(frame_result_t got);
      frame_result_t exp;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display(
            "%0t: unexpected result, expected none, actual cmd %h data %h has %b last %b",
            $time, got.command, got.data_byte, got.has_data, got.last);
        return;
      end
      exp = awaited_results.pop_front();
      if (got.command !== exp.command || got.data_byte !== exp.data_byte ||
          got.has_data !== exp.has_data || got.last !== exp.last) begin
        mismatches++;
        if (mismatches <= 40)
          $display(
            "%0t: expected cmd %h data %h has %b last %b, actual cmd %h data %h has %b last %b",
            $time, exp.command, exp.data_byte, exp.has_data, exp.last,
            got.command, got.data_byte, got.has_data, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  edf_rx_if  rx_ch ();
  edf_res_if res_ch ();
  edf_cfg_if cfg_ch ();

  escaped_frame_deframer uut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  deframe_scoreboard sb = new();
  logic [7:0] link_bytes [$];

  always #1 clk = ~clk;

  // Result side: check each transfer, then pick the next ready value from the stall pattern.
  int unsigned stall_mode  = 0;
  int unsigned stall_cycle = 0;

  always @(posedge clk) begin : result_sink
    frame_result_t got;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got = '{command: res_ch.command, data_byte: res_ch.data_byte,
                has_data: res_ch.has_data, last: res_ch.last};
        sb.compare_result(got);
      end
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 64 == 63) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0:       res_ch.ready <= 1'b1;
        1:       res_ch.ready <= 1'($urandom_range(0, 1));
        2:       res_ch.ready <= (stall_cycle % 4 == 0);
        default: res_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic write_limit(logic [6:0] value);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.raw_limit <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.raw_limit = value;
    cfg_ch.valid <= 1'b0;
  endtask

  // Drive the queued bytes in bursts; some streams run with no gaps at all.
  task automatic send_stream();
    int unsigned burst_left;
    bit          steady;
    logic [7:0]  b;
    burst_left = 0;
    steady     = ($urandom_range(0, 3) == 0);
    while (link_bytes.size() != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        if (!steady && $urandom_range(0, 2) != 0) begin
          rx_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 5)) @(posedge clk);
        end
      end
      b = link_bytes.pop_front();
      rx_ch.valid   <= 1'b1;
      rx_ch.in_byte <= b;
      do @(posedge clk); while (!rx_ch.ready);
      sb.decode_byte(b);
      burst_left--;
    end
    rx_ch.valid <= 1'b0;
  endtask

  // Wait for every expected result, then let queued bytes drain through the front.
  task automatic settle();
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  // Mostly well-formed frames with random content, plus line noise and broken frames.
  function automatic void queue_random_traffic(logic [6:0] limit, int unsigned target);
    int unsigned sent;
    int unsigned eff_limit;
    int unsigned n_raw;
    int unsigned kind;
    logic [7:0]  b;
    sent      = 0;
    eff_limit = (limit > BUFFER_BYTES) ? BUFFER_BYTES : limit;
    while (sent < target) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 3)) link_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (kind == 1) begin
        link_bytes.push_back(CH_START);
        n_raw = $urandom_range(0, 5);
        repeat (n_raw) link_bytes.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) link_bytes.push_back(CH_END);
        sent += n_raw + 1;
      end else begin
        if ($urandom_range(0, 9) == 0)
          n_raw = $urandom_range((eff_limit > 1) ? eff_limit - 2 : 0, eff_limit + 1);
        else
          n_raw = $urandom_range(0, 6);
        link_bytes.push_back(CH_START);
        link_bytes.push_back(8'($urandom_range(0, 255)));
        for (int unsigned i = 0; i < n_raw; i++) begin
          b = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 4) == 0) begin
            link_bytes.push_back(CH_ESC);
            case ($urandom_range(0, 2))
              0:       link_bytes.push_back(CH_ZERO);
              1:       link_bytes.push_back(CH_ONE);
              default: link_bytes.push_back(b);
            endcase
            i++;
          end else if (b == CH_ESC || b == CH_END) begin
            link_bytes.push_back(CH_ESC);
            link_bytes.push_back((b == CH_ESC) ? CH_ZERO : CH_ONE);
            i++;
          end else begin
            link_bytes.push_back(b);
          end
        end
        // occasionally end on a lone escape
        if ($urandom_range(0, 7) == 0) link_bytes.push_back(CH_ESC);
        link_bytes.push_back(CH_END);
        sent += n_raw + 3;
      end
    end
  endfunction

  task automatic run_phase(logic [6:0] limit, int unsigned target);
    queue_random_traffic(limit, target);
    write_limit(limit);
    send_stream();
    settle();
  endtask

  initial begin
    rst              <= 1'b1;
    rx_ch.valid      <= 1'b0;
    rx_ch.in_byte    <= 8'h00;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.raw_limit <= 7'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // line noise, bare terminator, empty payload, escapes, raw start byte, trailing escape
    link_bytes = {link_bytes, 8'h00, 8'hFF, CH_END, CH_ESC};
    link_bytes = {link_bytes, CH_START, CH_END};
    link_bytes = {link_bytes, CH_START, 8'h00, CH_END};
    link_bytes = {link_bytes, CH_START, 8'hFF, 8'h00, 8'hFF, CH_ESC, CH_ZERO, CH_ESC, CH_ONE,
                  CH_ESC, 8'h5A, CH_START, CH_END};
    link_bytes = {link_bytes, CH_START, 8'h43, CH_ESC, CH_END};
    run_phase(LIMIT_RESET, 10);

    // limit zero drops every frame
    link_bytes = {link_bytes, CH_START, 8'h43, CH_END};
    run_phase(7'd0, 5);

    // limit one: command only, then overflow on the first data byte
    link_bytes = {link_bytes, CH_START, 8'h43, CH_END, CH_START, 8'h43, 8'h44, CH_END};
    run_phase(7'd1, 8);

    link_bytes = {link_bytes, CH_START, 8'h43, 8'h44, 8'h45, CH_END};
    run_phase(7'd2, 8);

    run_phase(7'd127, 10);
    run_phase(7'($urandom_range(3, 63)), 10);
    run_phase(LIMIT_RESET, 10);

    if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
